// ===== sv/sio_pkg.sv =====
// ----------------------------------------------------------------------------
// sio_pkg
// Shared constants, command/status types and power-on tables of the
// super i/o configuration port.
// ----------------------------------------------------------------------------
package sio_pkg;

   localparam int NUM_DEVICES = 10;
   localparam int NUM_GLOBAL  = 48;
   localparam int DEV_W       = $clog2(NUM_DEVICES);
   localparam int DEV_DEPTH   = NUM_DEVICES * 256;
   localparam int DADDR_W     = DEV_W + 8;
   localparam int GIDX_W      = $clog2(NUM_GLOBAL);

   localparam logic [7:0] KEY_ENTER   = 8'h55;
   localparam logic [7:0] KEY_EXIT    = 8'hAA;
   localparam logic [7:0] REG_DEV_SEL = 8'h07;
   localparam logic [7:0] REG_ACT     = 8'h30;
   localparam logic [7:0] REG_BASE_HI = 8'h60;
   localparam logic [7:0] REG_BASE_LO = 8'h61;
   localparam logic [7:0] REG_IRQ     = 8'h70;

   localparam logic [7:0] DEV_FDD  = 8'd0;
   localparam logic [7:0] DEV_LPT  = 8'd3;
   localparam logic [7:0] DEV_COM1 = 8'd4;
   localparam logic [7:0] DEV_COM2 = 8'd5;

   localparam logic [3:0] EV_NONE        = 4'd0;
   localparam logic [3:0] EV_FDD_ATTACH  = 4'd1;
   localparam logic [3:0] EV_FDD_REMOVE  = 4'd2;
   localparam logic [3:0] EV_LPT_ATTACH  = 4'd3;
   localparam logic [3:0] EV_LPT_REMOVE  = 4'd4;
   localparam logic [3:0] EV_COM1_SET    = 4'd5;
   localparam logic [3:0] EV_COM1_REMOVE = 4'd6;
   localparam logic [3:0] EV_COM2_SET    = 4'd7;
   localparam logic [3:0] EV_COM2_REMOVE = 4'd8;

   typedef enum logic [2:0] {
      ADDR_INDEX, ADDR_ACT, ADDR_HI, ADDR_LO, ADDR_IRQ
   } addr_sel_type;

   typedef enum logic [1:0] {WR_VAL, WR_HI, WR_LO} wr_sel_type;

   typedef enum logic [2:0] {
      CAP_NONE, CAP_OLD, CAP_ACT, CAP_HI, CAP_LO, CAP_IRQ
   } cap_sel_type;

   typedef enum logic [1:0] {RES_PLAIN, RES_MEM, RES_EVENT} res_sel_type;

   typedef struct packed {
      logic         clear_wr;
      logic         load_req;
      logic         key_update;
      logic         g_wr;
      logic         rd;
      logic         d_wr;
      addr_sel_type addr_sel;
      wr_sel_type   wr_sel;
      cap_sel_type  cap_sel;
      logic         eval;
      logic         finish;
      res_sel_type  res_sel;
   } cmd_type;

   typedef struct packed {
      logic is_read;
      logic is_data;
      logic in_config;
      logic reg_global;
      logic drop;
      logic store;
      logic clear_last;
      logic rsp_free;
   } status_type;

   function automatic logic [7:0] glob_init(logic [GIDX_W-1:0] idx);
      logic [7:0] v;
      case (int'(idx))
         3:       v = 8'h03;
         32:      v = 8'h03;
         33:      v = 8'h01;
         36:      v = 8'h04;
         38:      v = 8'hF0;
         39:      v = 8'h03;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] dev_init(logic [DEV_W-1:0] dev, logic [7:0] r);
      logic [7:0] v;
      v = 8'h00;
      case (int'(dev))
         0: case (r)
               8'h30: v = 8'h01; 8'h60: v = 8'h03; 8'h61: v = 8'hF0;
               8'h70: v = 8'h06; 8'h74: v = 8'h02; 8'hF0: v = 8'h0E;
               8'hF2: v = 8'hFF; default: v = 8'h00;
            endcase
         1: case (r)
               8'h30: v = 8'h01; 8'h60: v = 8'h01; 8'h61: v = 8'hF0;
               8'h62: v = 8'h03; 8'h63: v = 8'hF6; 8'h70: v = 8'h0E;
               8'hF0: v = 8'h0C; default: v = 8'h00;
            endcase
         2: case (r)
               8'h30: v = 8'h01; 8'h60: v = 8'h01; 8'h61: v = 8'h70;
               8'h62: v = 8'h03; 8'h63: v = 8'h76; 8'h70: v = 8'h0F;
               default: v = 8'h00;
            endcase
         3: case (r)
               8'h30: v = 8'h01; 8'h60: v = 8'h03; 8'h61: v = 8'h78;
               8'h70: v = 8'h07; 8'h74: v = 8'h04; 8'hF0: v = 8'h3C;
               default: v = 8'h00;
            endcase
         4: case (r)
               8'h30: v = 8'h01; 8'h60: v = 8'h03; 8'h61: v = 8'hF8;
               8'h70: v = 8'h04; 8'hF0: v = 8'h03; default: v = 8'h00;
            endcase
         5: case (r)
               8'h30: v = 8'h01; 8'h60: v = 8'h02; 8'h61: v = 8'hF8;
               8'h70: v = 8'h03; 8'h74: v = 8'h04; 8'hF1: v = 8'h02;
               8'hF2: v = 8'h03; default: v = 8'h00;
            endcase
         6: case (r)
               8'h63: v = 8'h70; 8'hF4: v = 8'h03; default: v = 8'h00;
            endcase
         7: case (r)
               8'h30: v = 8'h01; 8'h61: v = 8'h60; 8'h70: v = 8'h01;
               default: v = 8'h00;
            endcase
         default: v = 8'h00;
      endcase
      return v;
   endfunction

endpackage

// ===== sv/sio_if.sv =====
// ----------------------------------------------------------------------------
// sio_if
// Valid/ready channels of the configuration port: bus access in, result out.
// ----------------------------------------------------------------------------
interface sio_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic       port_select;
   logic [7:0] write_data;
   modport source(output valid, req_type, port_select, write_data, input ready);
   modport sink(input valid, req_type, port_select, write_data, output ready);
endinterface

interface sio_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic        config_mode;
   logic [3:0]  event_kind;
   logic [11:0] event_base;
   logic [7:0]  event_irq;
   modport source(output valid, read_data, config_mode, event_kind, event_base,
                  event_irq, input ready);
   modport sink(input valid, read_data, config_mode, event_kind, event_base,
                event_irq, output ready);
endinterface

// ===== sv/sio_dp.sv =====
// ----------------------------------------------------------------------------
// sio_dp
// Datapath: mode and index registers, global and device register memories,
// base validation, event formation and the result register.
// ----------------------------------------------------------------------------
module sio_dp (
   input  logic                clock,
   input  logic                reset,
   input  sio_pkg::cmd_type    cmd,
   output sio_pkg::status_type status,
   input  logic                req_type,
   input  logic                port_select,
   input  logic [7:0]          write_data,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [7:0]          read_data,
   output logic                config_mode,
   output logic [3:0]          event_kind,
   output logic [11:0]         event_base,
   output logic [7:0]          event_irq
);

   logic                        req_type_ff, port_sel_ff;
   logic [7:0]                  wdata_ff;
   logic                        in_config_ff, in_config_in;
   logic                        key_seen_ff, key_seen_in;
   logic [7:0]                  reg_index_ff, reg_index_in;
   logic [7:0]                  dev_sel_ff;
   logic [sio_pkg::DADDR_W-1:0] clr_cnt_ff;

   logic [7:0] g_mem [0:sio_pkg::NUM_GLOBAL-1];
   logic [7:0] d_mem [0:sio_pkg::DEV_DEPTH-1];
   logic [7:0] g_rdata_ff, d_rdata_ff;

   logic [7:0]  old_ff, act_ff, hi_ff, lo_ff, irq_ff;
   logic [3:0]  ev_kind_ff, ev_kind_in;
   logic [11:0] ev_base_ff, ev_base_in;
   logic [7:0]  ev_irq_ff, ev_irq_in;
   logic        store_ff, store_in;

   logic                        rsp_valid_ff;
   logic [7:0]                  rd_out_ff;
   logic                        cfg_out_ff;
   logic [3:0]                  kind_out_ff;
   logic [11:0]                 base_out_ff;
   logic [7:0]                  irq_out_ff;

   logic                        dev_ok, reg_global;
   logic [7:0]                  mem_reg;
   logic [sio_pkg::DADDR_W-1:0] d_addr;
   logic [7:0]                  d_wdata;
   logic                        d_we, d_re;
   logic [sio_pkg::GIDX_W-1:0]  g_addr;
   logic                        g_we, g_re;
   logic [7:0]                  g_wdata;
   logic [7:0]                  e30, e60, e61, e70;
   logic                        diff, active, base_reg;
   logic [11:0]                 vbase;
   logic [7:0]                  res_rd;

   function automatic logic [11:0] pick_base(logic [7:0] dev, logic [7:0] hi,
                                             logic [7:0] lo);
      logic [11:0] p;
      logic [11:0] dflt;
      logic        hit;
      p = {hi[3:0], lo[7:3], 3'b000};
      if (dev == sio_pkg::DEV_FDD) begin
         hit  = (p == 12'h3F0) || (p == 12'h370);
         dflt = 12'h3F0;
      end else if (dev == sio_pkg::DEV_LPT) begin
         hit  = (p == 12'h3BC) || (p == 12'h378) || (p == 12'h278);
         dflt = 12'h378;
      end else begin
         hit  = (p == 12'h3F8) || (p == 12'h2F8) || (p == 12'h338) ||
                (p == 12'h3E8) || (p == 12'h2E8) || (p == 12'h220) ||
                (p == 12'h238) || (p == 12'h2E0) || (p == 12'h228);
         dflt = (dev == sio_pkg::DEV_COM1) ? 12'h3F8 : 12'h2F8;
      end
      if ((p < 12'h100) || !hit) p = dflt;
      return p;
   endfunction

   assign dev_ok     = dev_sel_ff < 8'(sio_pkg::NUM_DEVICES);
   assign reg_global = reg_index_ff < 8'(sio_pkg::NUM_GLOBAL);

   assign status.is_read    = req_type_ff;
   assign status.is_data    = port_sel_ff;
   assign status.in_config  = in_config_ff;
   assign status.reg_global = reg_global;
   assign status.drop       = ((reg_index_ff[7:4] == 4'h7) && (dev_sel_ff < 8'd4)) ||
                              (dev_sel_ff == 8'd1) || (dev_sel_ff == 8'd2) ||
                              (dev_sel_ff > 8'd5);
   assign status.store      = store_ff;
   assign status.clear_last = clr_cnt_ff == sio_pkg::DADDR_W'(sio_pkg::DEV_DEPTH - 1);
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   // key sequence and index
   always_comb begin
      in_config_in = in_config_ff;
      key_seen_in  = key_seen_ff;
      reg_index_in = reg_index_ff;
      if (cmd.key_update) begin
         if ((wdata_ff == sio_pkg::KEY_ENTER) && !in_config_ff) begin
            if (key_seen_ff) begin
               in_config_in = 1'b1;
               key_seen_in  = 1'b0;
            end else begin
               key_seen_in = 1'b1;
            end
         end else if (in_config_ff) begin
            if (wdata_ff == sio_pkg::KEY_EXIT) in_config_in = 1'b0;
            else reg_index_in = wdata_ff;
         end else begin
            key_seen_in = 1'b0;
         end
      end
   end

   // memory ports
   always_comb begin
      case (cmd.addr_sel)
         sio_pkg::ADDR_ACT: mem_reg = sio_pkg::REG_ACT;
         sio_pkg::ADDR_HI:  mem_reg = sio_pkg::REG_BASE_HI;
         sio_pkg::ADDR_LO:  mem_reg = sio_pkg::REG_BASE_LO;
         sio_pkg::ADDR_IRQ: mem_reg = sio_pkg::REG_IRQ;
         default:           mem_reg = reg_index_ff;
      endcase
      if (cmd.clear_wr) d_addr = clr_cnt_ff;
      else d_addr = {dev_sel_ff[sio_pkg::DEV_W-1:0], mem_reg};
      if (cmd.clear_wr) begin
         d_wdata = sio_pkg::dev_init(clr_cnt_ff[sio_pkg::DADDR_W-1:8], clr_cnt_ff[7:0]);
      end else begin
         case (cmd.wr_sel)
            sio_pkg::WR_HI: d_wdata = {4'h0, ev_base_ff[11:8]};
            sio_pkg::WR_LO: d_wdata = ev_base_ff[7:0];
            default:        d_wdata = wdata_ff;
         endcase
      end
      d_we = cmd.clear_wr || cmd.d_wr;
      d_re = cmd.rd && dev_ok;
      g_addr = cmd.clear_wr ? clr_cnt_ff[sio_pkg::GIDX_W-1:0]
                            : reg_index_ff[sio_pkg::GIDX_W-1:0];
      g_wdata = cmd.clear_wr ? sio_pkg::glob_init(clr_cnt_ff[sio_pkg::GIDX_W-1:0])
                             : wdata_ff;
      g_we = (cmd.clear_wr && (clr_cnt_ff < sio_pkg::DADDR_W'(sio_pkg::NUM_GLOBAL))) ||
             cmd.g_wr;
      g_re = cmd.rd && reg_global;
   end

   always_ff @(posedge clock) begin
      if (d_we) d_mem[d_addr] <= d_wdata;
      if (d_re) d_rdata_ff <= d_mem[d_addr];
   end

   always_ff @(posedge clock) begin
      if (g_we) g_mem[g_addr] <= g_wdata;
      if (g_re) g_rdata_ff <= g_mem[g_addr];
   end

   // event evaluation on the post-write register view
   always_comb begin
      e30 = (reg_index_ff == sio_pkg::REG_ACT)     ? wdata_ff : act_ff;
      e60 = (reg_index_ff == sio_pkg::REG_BASE_HI) ? wdata_ff : hi_ff;
      e61 = (reg_index_ff == sio_pkg::REG_BASE_LO) ? wdata_ff : lo_ff;
      e70 = (reg_index_ff == sio_pkg::REG_IRQ)     ? wdata_ff : irq_ff;
      diff     = wdata_ff != old_ff;
      active   = e30 != 8'h00;
      base_reg = (reg_index_ff == sio_pkg::REG_BASE_HI) ||
                 (reg_index_ff == sio_pkg::REG_BASE_LO);
      vbase    = pick_base(dev_sel_ff, e60, e61);
      ev_kind_in = sio_pkg::EV_NONE;
      ev_base_in = 12'h000;
      ev_irq_in  = 8'h00;
      store_in   = 1'b0;
      if (dev_sel_ff == sio_pkg::DEV_FDD) begin
         if ((reg_index_ff == sio_pkg::REG_ACT) && diff) begin
            if (wdata_ff == 8'h00) begin
               ev_kind_in = sio_pkg::EV_FDD_REMOVE;
            end else begin
               ev_kind_in = sio_pkg::EV_FDD_ATTACH;
               ev_base_in = vbase;
            end
         end else if (base_reg && diff && active) begin
            ev_kind_in = sio_pkg::EV_FDD_ATTACH;
            ev_base_in = vbase;
            store_in   = 1'b1;
         end
      end else if (dev_sel_ff == sio_pkg::DEV_LPT) begin
         if ((reg_index_ff == sio_pkg::REG_ACT) && diff) begin
            if (wdata_ff == 8'h00) begin
               ev_kind_in = sio_pkg::EV_LPT_REMOVE;
            end else begin
               ev_kind_in = sio_pkg::EV_LPT_ATTACH;
               ev_base_in = vbase;
               store_in   = 1'b1;
            end
         end else if (base_reg && diff && active) begin
            ev_kind_in = sio_pkg::EV_LPT_ATTACH;
            ev_base_in = vbase;
            store_in   = 1'b1;
         end
      end else begin
         if ((reg_index_ff == sio_pkg::REG_ACT) && diff) begin
            if (wdata_ff == 8'h00) begin
               ev_kind_in = (dev_sel_ff == sio_pkg::DEV_COM1) ? sio_pkg::EV_COM1_REMOVE
                                                              : sio_pkg::EV_COM2_REMOVE;
            end else begin
               ev_kind_in = (dev_sel_ff == sio_pkg::DEV_COM1) ? sio_pkg::EV_COM1_SET
                                                              : sio_pkg::EV_COM2_SET;
               ev_base_in = vbase;
               ev_irq_in  = e70;
               store_in   = 1'b1;
            end
         end else if ((base_reg || (reg_index_ff == sio_pkg::REG_IRQ)) && diff && active) begin
            ev_kind_in = (dev_sel_ff == sio_pkg::DEV_COM1) ? sio_pkg::EV_COM1_SET
                                                           : sio_pkg::EV_COM2_SET;
            ev_base_in = vbase;
            ev_irq_in  = e70;
            store_in   = 1'b1;
         end
      end
   end

   always_comb begin
      if (reg_global) res_rd = g_rdata_ff;
      else if (dev_ok) res_rd = d_rdata_ff;
      else res_rd = 8'hFF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_config_ff <= 1'b0;
         key_seen_ff  <= 1'b0;
         reg_index_ff <= 8'h00;
         dev_sel_ff   <= 8'h00;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_config_ff <= in_config_in;
         key_seen_ff  <= key_seen_in;
         reg_index_ff <= reg_index_in;
         if (cmd.g_wr && (reg_index_ff == sio_pkg::REG_DEV_SEL)) dev_sel_ff <= wdata_ff;
         if (cmd.clear_wr) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (cmd.finish) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_type_ff <= req_type;
         port_sel_ff <= port_select;
         wdata_ff    <= write_data;
      end
      case (cmd.cap_sel)
         sio_pkg::CAP_OLD: old_ff <= d_rdata_ff;
         sio_pkg::CAP_ACT: act_ff <= d_rdata_ff;
         sio_pkg::CAP_HI:  hi_ff  <= d_rdata_ff;
         sio_pkg::CAP_LO:  lo_ff  <= d_rdata_ff;
         sio_pkg::CAP_IRQ: irq_ff <= d_rdata_ff;
         default: ;
      endcase
      if (cmd.eval) begin
         ev_kind_ff <= ev_kind_in;
         ev_base_ff <= ev_base_in;
         ev_irq_ff  <= ev_irq_in;
         store_ff   <= store_in;
      end
      if (cmd.finish) begin
         cfg_out_ff <= in_config_in;
         case (cmd.res_sel)
            sio_pkg::RES_MEM: begin
               rd_out_ff   <= res_rd;
               kind_out_ff <= sio_pkg::EV_NONE;
               base_out_ff <= 12'h000;
               irq_out_ff  <= 8'h00;
            end
            sio_pkg::RES_EVENT: begin
               rd_out_ff   <= 8'h00;
               kind_out_ff <= ev_kind_ff;
               base_out_ff <= ev_base_ff;
               irq_out_ff  <= ev_irq_ff;
            end
            default: begin
               if (!req_type_ff) rd_out_ff <= 8'h00;
               else if (in_config_ff) rd_out_ff <= reg_index_ff;
               else rd_out_ff <= 8'hFF;
               kind_out_ff <= sio_pkg::EV_NONE;
               base_out_ff <= 12'h000;
               irq_out_ff  <= 8'h00;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign read_data   = rd_out_ff;
   assign config_mode = cfg_out_ff;
   assign event_kind  = kind_out_ff;
   assign event_base  = base_out_ff;
   assign event_irq   = irq_out_ff;

endmodule

// ===== sv/sio_ctrl.sv =====
// ----------------------------------------------------------------------------
// sio_ctrl
// Controller: clearing sweep, access decode and the device write sequence.
// ----------------------------------------------------------------------------
module sio_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sio_pkg::status_type status,
   output sio_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DEC, S_RDONE, S_RD_ACT, S_RD_HI, S_RD_LO, S_RD_IRQ,
      S_WR_VAL, S_EVAL, S_WB_HI, S_WB_LO
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE) && status.rsp_free;

   always_comb begin
      cmd          = '0;
      cmd.addr_sel = sio_pkg::ADDR_INDEX;
      cmd.wr_sel   = sio_pkg::WR_VAL;
      cmd.cap_sel  = sio_pkg::CAP_NONE;
      cmd.res_sel  = sio_pkg::RES_PLAIN;
      state_in     = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load_req = 1'b1;
               state_in     = S_DEC;
            end
         end
         S_DEC: begin
            if (status.is_read) begin
               if (status.in_config && status.is_data) begin
                  cmd.rd   = 1'b1;
                  state_in = S_RDONE;
               end else begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            end else if (!status.is_data) begin
               cmd.key_update = 1'b1;
               cmd.finish     = 1'b1;
               state_in       = S_IDLE;
            end else if (!status.in_config || status.reg_global || status.drop) begin
               cmd.g_wr   = status.in_config && status.reg_global;
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_RD_ACT;
            end
         end
         S_RDONE: begin
            cmd.finish  = 1'b1;
            cmd.res_sel = sio_pkg::RES_MEM;
            state_in    = S_IDLE;
         end
         S_RD_ACT: begin
            cmd.cap_sel  = sio_pkg::CAP_OLD;
            cmd.rd       = 1'b1;
            cmd.addr_sel = sio_pkg::ADDR_ACT;
            state_in     = S_RD_HI;
         end
         S_RD_HI: begin
            cmd.cap_sel  = sio_pkg::CAP_ACT;
            cmd.rd       = 1'b1;
            cmd.addr_sel = sio_pkg::ADDR_HI;
            state_in     = S_RD_LO;
         end
         S_RD_LO: begin
            cmd.cap_sel  = sio_pkg::CAP_HI;
            cmd.rd       = 1'b1;
            cmd.addr_sel = sio_pkg::ADDR_LO;
            state_in     = S_RD_IRQ;
         end
         S_RD_IRQ: begin
            cmd.cap_sel  = sio_pkg::CAP_LO;
            cmd.rd       = 1'b1;
            cmd.addr_sel = sio_pkg::ADDR_IRQ;
            state_in     = S_WR_VAL;
         end
         S_WR_VAL: begin
            cmd.cap_sel = sio_pkg::CAP_IRQ;
            cmd.d_wr    = 1'b1;
            state_in    = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_WB_HI;
         end
         S_WB_HI: begin
            cmd.d_wr     = status.store;
            cmd.wr_sel   = sio_pkg::WR_HI;
            cmd.addr_sel = sio_pkg::ADDR_HI;
            state_in     = S_WB_LO;
         end
         S_WB_LO: begin
            cmd.d_wr     = status.store;
            cmd.wr_sel   = sio_pkg::WR_LO;
            cmd.addr_sel = sio_pkg::ADDR_LO;
            cmd.finish   = 1'b1;
            cmd.res_sel  = sio_pkg::RES_EVENT;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else state_ff <= state_in;
   end

endmodule

// ===== sv/superio_config_register_port.sv =====
// ----------------------------------------------------------------------------
// superio_config_register_port
// Index/data configuration port with global and logical-device registers.
// ----------------------------------------------------------------------------
// After reset the block loads its power-on register values with a sweep over
// all NUM_DEVICES*256 device register addresses (2560 by default) and accepts
// no access until it is done. Each access then runs alone through a
// single-port register memory: index-port accesses, reads outside
// configuration mode and writes that change no device register end at decode,
// a data read adds a memory read, and a device register write runs the five
// reads, the write, the event evaluation and two base write-backs on one port.
// A new access is accepted only once the previous result has left the
// output register or is taken in the same cycle.
module superio_config_register_port (
   input  logic  clock,
   input  logic  reset,
   sio_req_if.sink   req_bus,
   sio_rsp_if.source rsp_bus
);

   sio_pkg::cmd_type    cmd;
   sio_pkg::status_type status;

   sio_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sio_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_type    (req_bus.req_type),
      .port_select (req_bus.port_select),
      .write_data  (req_bus.write_data),
      .rsp_ready   (rsp_bus.ready),
      .rsp_valid   (rsp_bus.valid),
      .read_data   (rsp_bus.read_data),
      .config_mode (rsp_bus.config_mode),
      .event_kind  (rsp_bus.event_kind),
      .event_base  (rsp_bus.event_base),
      .event_irq   (rsp_bus.event_irq)
   );

endmodule

// ===== sv/sio_chk.sv =====
// ----------------------------------------------------------------------------
// sio_chk
// Port-level checks of the configuration port, bound to the top level.
// ----------------------------------------------------------------------------
module sio_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_config_mode,
   input logic [3:0] rsp_event_kind
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before it was taken");

   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("access taken during register load");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second access taken while one is in work");

   a_event_in_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind != sio_pkg::EV_NONE) |-> rsp_config_mode)
      else $error("device event outside configuration mode");

   a_event_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_kind <= sio_pkg::EV_COM2_REMOVE))
      else $error("undefined event code");

endmodule

bind superio_config_register_port sio_chk u_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_config_mode (rsp_bus.config_mode),
   .rsp_event_kind  (rsp_bus.event_kind)
);
